// File: rtl/core/fpd_pkg.sv
// Shared types and constants for the 16.16 saturating divider.
package fpd_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned SatShift = 14;
  // Unsaturated quotients stay below 2^(FracBits + SatShift)
  localparam int unsigned QuotW    = FracBits + SatShift;

  localparam logic [WordW-1:0] MostNeg = {1'b1, {(WordW-1){1'b0}}};
  localparam logic [WordW-1:0] MostPos = {1'b0, {(WordW-1){1'b1}}};

  typedef struct packed {
    logic signed [WordW-1:0] dividend;
    logic signed [WordW-1:0] divisor;
  } fpd_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] quotient;
    logic                    saturated;
  } fpd_out_t;

  // State carried between divider stages
  typedef struct packed {
    logic             valid;
    logic             differ;
    logic             sat;
    logic [WordW-1:0] ua;
    logic [WordW-1:0] ub;
    logic [WordW-1:0] rem;
    logic [QuotW-1:0] quo;
  } fpd_work_t;

endpackage

// File: rtl/core/fixed_point_divide_16_16_unit.sv
// Pipeline: one input stage, 30 quotient stages and one output stage (1 + 30 + 1 stages).
// Throughput: one item per cycle unless the output stalls; one quotient bit is
// resolved per stage by a 33-bit compare and subtract, thirty stages in a row.
// The whole pipeline advances together and holds while the output item is stalled.
// Reset clears all valid bits asynchronously; payload registers are not reset.
module fixed_point_divide_16_16_unit import fpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fpd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fpd_out_t out_data_o
);

  logic      en;
  fpd_work_t work [QuotW+1];

  // Advance unless a finished item is waiting at a stalled output
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  fpd_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .work_o  (work[0])
  );

  for (genvar s = 0; s < QuotW; s++) begin : g_step
    fpd_stage #(
      .Step (s)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .work_i (work[s]),
      .work_o (work[s+1])
    );
  end

  fpd_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .work_i  (work[QuotW]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

// File: rtl/core/fpd_prep.sv
// Input stage: operand magnitudes, sign and overflow check.
module fpd_prep import fpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  fpd_in_t   data_i,
  output fpd_work_t work_o
);

  logic [WordW-1:0] a, b, ua, ub;
  logic [WordW-SatShift-1:0] ua_hi;
  logic      valid_q;
  fpd_work_t work_d, work_q;

  always_comb begin
    a      = data_i.dividend;
    b      = data_i.divisor;
    ua     = a[WordW-1] ? (~a + 1'b1) : a;
    ub     = b[WordW-1] ? (~b + 1'b1) : b;
    ua_hi  = ua[WordW-1:SatShift];
    work_d.valid  = valid_i;
    work_d.differ = a[WordW-1] ^ b[WordW-1];
    work_d.sat    = {{SatShift{1'b0}}, ua_hi} >= ub;
    work_d.ua     = ua;
    work_d.ub     = ub;
    // Leading quotient bits are zero when not saturated: start from ua >> SatShift
    work_d.rem    = {{SatShift{1'b0}}, ua_hi};
    work_d.quo    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= work_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  // Take the valid bit from the reset register
  always_comb begin
    work_o       = work_q;
    work_o.valid = valid_q;
  end

endmodule

// File: rtl/core/fpd_stage.sv
// One restoring-division step: resolves one quotient bit per stage.
module fpd_stage import fpd_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  fpd_work_t work_i,
  output fpd_work_t work_o
);

  localparam int unsigned Bit = QuotW - 1 - Step;

  logic             nbit;
  logic [WordW:0]   trial;
  logic [WordW:0]   diff;
  logic             ge;
  logic             valid_q;
  fpd_work_t        work_d, work_q;

  // Next bit of the dividend shifted left by FracBits
  if (Bit >= FracBits) begin : g_num
    assign nbit = work_i.ua[Bit-FracBits];
  end else begin : g_zero
    assign nbit = 1'b0;
  end

  always_comb begin
    trial  = {work_i.rem, nbit};
    diff   = trial - {1'b0, work_i.ub};
    ge     = trial >= {1'b0, work_i.ub};
    work_d = work_i;
    work_d.rem = ge ? diff[WordW-1:0] : trial[WordW-1:0];
    work_d.quo[Bit] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= work_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  // Take the valid bit from the reset register
  always_comb begin
    work_o       = work_q;
    work_o.valid = valid_q;
  end

endmodule

// File: rtl/core/fpd_post.sv
// Output stage: sign restore, saturation select and output register.
module fpd_post import fpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  fpd_work_t work_i,
  output logic      valid_o,
  output fpd_out_t  data_o
);

  logic [WordW-1:0] mag;
  fpd_out_t         data_d, data_q;
  logic             valid_q;

  always_comb begin
    mag = {{(WordW-QuotW){1'b0}}, work_i.quo};
    if (work_i.sat) begin
      data_d.quotient = work_i.differ ? MostNeg : MostPos;
    end else begin
      data_d.quotient = work_i.differ ? (~mag + 1'b1) : mag;
    end
    data_d.saturated = work_i.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= work_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the saturating 16.16 fixed-point divider.
module tb import fpd_pkg::*; ();

  localparam int unsigned ItemsPerPhase = 550;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned QuietLimit    = 2000;

  class division_scoreboard;
    fpd_out_t quotients_due[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function fpd_out_t divide_q16(fpd_in_t item);
      logic [WordW-1:0] mag_a;
      logic [WordW-1:0] mag_b;
      logic [WordW-1:0] raw;
      logic [WordW+FracBits-1:0] wide;
      logic signs_differ;
      fpd_out_t res;
      mag_a = item.dividend;
      mag_b = item.divisor;
      // Magnitudes are unsigned, so the most negative word stays 2^31
      if (mag_a[WordW-1]) mag_a = -mag_a;
      if (mag_b[WordW-1]) mag_b = -mag_b;
      signs_differ = item.dividend[WordW-1] ^ item.divisor[WordW-1];
      if ((mag_a >> SatShift) >= mag_b) begin
        res.quotient  = signs_differ ? MostNeg : MostPos;
        res.saturated = 1'b1;
      end else begin
        wide = {mag_a, {FracBits{1'b0}}} / mag_b;
        raw  = wide[WordW-1:0];
        res.quotient  = signs_differ ? -raw : raw;
        res.saturated = 1'b0;
      end
      return res;
    endfunction

    function void note_division(fpd_in_t item);
      quotients_due.push_back(divide_q16(item));
    endfunction

    function void check_quotient(fpd_out_t got);
      fpd_out_t want;
      if (quotients_due.size() == 0) begin
        $error("unexpected item: quotient %h saturated %0b", got.quotient, got.saturated);
        failures++;
        return;
      end
      want = quotients_due.pop_front();
      if (got.quotient !== want.quotient) begin
        $error("quotient mismatch: expected %h, actual %h", want.quotient, got.quotient);
        failures++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated mismatch: expected %0b, actual %0b", want.saturated, got.saturated);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return quotients_due.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  fpd_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  fpd_out_t out_data_o;

  division_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  fixed_point_divide_16_16_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Note accepted inputs and check accepted results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_division(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_quotient(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("fixed_point_divide_16_16_unit regression: fail");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_division(input fpd_in_t item);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [WordW-1:0] scaled_operand();
    logic [WordW-1:0] v;
    v = $urandom >> $urandom_range(31, 0);
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  function automatic logic [WordW-1:0] extreme_operand();
    case ($urandom_range(4))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return MostNeg;
      default: return MostPos;
    endcase
  endfunction

  function automatic fpd_in_t random_division();
    fpd_in_t item;
    logic [WordW-1:0] mag_b;
    case ($urandom_range(9))
      0, 1, 2: begin
        item.dividend = $urandom;
        item.divisor  = $urandom;
      end
      3, 4, 5, 6: begin
        item.dividend = scaled_operand();
        item.divisor  = scaled_operand();
      end
      7, 8: begin
        // Land just around the saturation threshold
        mag_b = $urandom_range(131071, 1);
        item.dividend = (mag_b << SatShift) + $urandom_range(4) - 2;
        item.divisor  = mag_b;
        if ($urandom_range(1)) item.dividend = -item.dividend;
        if ($urandom_range(1)) item.divisor  = -item.divisor;
      end
      default: begin
        item.dividend = $urandom_range(1) ? extreme_operand() : scaled_operand();
        item.divisor  = $urandom_range(1) ? extreme_operand() : scaled_operand();
      end
    endcase
    return item;
  endfunction

  initial begin
    fpd_in_t directed[$];
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    rst_ni      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed.push_back('{32'sd0, 32'sd0});
    directed.push_back('{-32'sd5, 32'sd0});
    directed.push_back('{MostPos, 32'sd0});
    directed.push_back('{MostNeg, 32'sd0});
    directed.push_back('{MostNeg, MostNeg});
    directed.push_back('{MostPos, MostNeg});
    directed.push_back('{MostNeg, MostPos});
    directed.push_back('{MostPos, MostPos});
    directed.push_back('{MostPos, 32'sd1});
    directed.push_back('{MostNeg, 32'sd1});
    directed.push_back('{32'sd1, MostPos});
    directed.push_back('{-32'sd1, 32'sd1});
    directed.push_back('{32'sd5, -32'sd1});
    directed.push_back('{32'sd0, 32'sd5});
    directed.push_back('{32'sd0, -32'sd5});
    directed.push_back('{32'sd49152, 32'sd3});
    directed.push_back('{32'sd49151, 32'sd3});
    directed.push_back('{-32'sd49151, 32'sd3});
    directed.push_back('{32'sd65536, 32'sd65536});
    directed.push_back('{32'sd229376, -32'sd131072});
    directed.push_back('{-32'sd65536, -32'sd196608});
    directed.push_back('{-32'sd1, -32'sd2});

    send_idle_pct = 20;
    recv_idle_pct = 70;
    foreach (directed[i]) send_division(directed[i]);
    repeat (ItemsPerPhase) send_division(random_division());

    send_idle_pct = 70;
    recv_idle_pct = 20;
    repeat (ItemsPerPhase) send_division(random_division());

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Long output hold-off while items keep coming, to back up the pipeline
    hold_request = 1'b1;
    repeat (ItemsPerPhase) send_division(random_division());

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.failures == 0) begin
      $display("fixed_point_divide_16_16_unit regression: pass");
    end else begin
      $display("fixed_point_divide_16_16_unit regression: fail");
    end
    $finish;
  end

endmodule
